// File: hw/rtl/bleadv_pkg.sv
// shared types, constants and bit-level helpers for the ble advertising encoder
package bleadv_pkg;

  localparam int unsigned CRC_W  = 24;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAN_W = 6;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0]  CRC_POLY     = 24'h00065B;
  localparam logic [BYTE_W-1:0] LFSR_TAPS    = 8'h11;
  localparam logic [BYTE_W-1:0] WHT_SEED_SET = 8'h02;
  localparam logic [CRC_W-1:0]  CRC_SEED_RST = 24'h555555;
  localparam logic [CHAN_W-1:0] CHAN_RST     = 6'd37;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] lfsr;
    logic [BYTE_W-1:0] data;
  } wht_res_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] a);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[BYTE_W-1-k] = a[k];
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] whiten_seed(input logic [CHAN_W-1:0] chan);
    return rev8({2'b00, chan}) | WHT_SEED_SET;
  endfunction

  // eight crc steps, data lsb first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    logic             top;
    c = crc;
    for (int k = 0; k < BYTE_W; k++) begin
      top = c[CRC_W-1];
      c   = {c[CRC_W-2:0], 1'b0};
      if (top != d[k]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // eight lfsr steps, one per data bit
  function automatic wht_res_t whiten(input logic [BYTE_W-1:0] lfsr,
                                      input logic [BYTE_W-1:0] d);
    wht_res_t r;
    r.lfsr = lfsr;
    r.data = d;
    for (int k = 0; k < BYTE_W; k++) begin
      if (r.lfsr[BYTE_W-1]) begin
        r.lfsr    = r.lfsr ^ LFSR_TAPS;
        r.data[k] = ~r.data[k];
      end
      r.lfsr = {r.lfsr[BYTE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ble_adv_packet_crc_whitener.sv
// ble advertising encoder: crc24 append and whitening; one word per cycle while out_ready
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, in_data_byte, in_last_byte  | sink
//  out     | out_valid, out_ready, out_byte, out_is_crc,     | source
//          | out_end_of_packet                               |
//  cfg     | cfg_we, cfg_index, cfg_data                     | sink
//
// one payload word per cycle while in_ready is high; a word marked last adds 3 crc words
// crc and lfsr steps run between the input and the output register
// the output register takes a new word whenever it is empty or being read
// while crc words are pending the input is held off
// synchronous active-low reset; seed and channel are sampled on the first word of a packet
module ble_adv_packet_crc_whitener (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_is_crc,
  output logic                               out_end_of_packet,
  input  logic                               cfg_we,
  input  logic [bleadv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bleadv_pkg::CFG_W-1:0]       cfg_data
);
  import bleadv_pkg::*;

  logic [CRC_W-1:0]  seed_r;
  logic [CHAN_W-1:0] chan_r;

  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] wht_r, wht_nxt;
  logic              start_r, start_nxt;
  logic [1:0]        crc_left_r, crc_left_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              is_crc_r, is_crc_nxt;
  logic              eop_r, eop_nxt;

  logic              out_free;
  logic              in_fire;
  logic [CRC_W-1:0]  crc_base;
  logic [BYTE_W-1:0] wht_base;
  logic [BYTE_W-1:0] crc_sel;
  wht_res_t          pay_wht;
  wht_res_t          crc_wht;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (crc_left_r == 2'd0) && out_free;
  assign in_fire  = in_valid && in_ready;

  // first word of a packet starts from the configured seeds
  assign crc_base = start_r ? seed_r : crc_r;
  assign wht_base = start_r ? whiten_seed(chan_r) : wht_r;
  assign pay_wht  = whiten(wht_base, in_data_byte);

  always_comb begin
    case (crc_left_r)
      2'd3:    crc_sel = crc_r[23:16];
      2'd2:    crc_sel = crc_r[15:8];
      default: crc_sel = crc_r[7:0];
    endcase
  end

  assign crc_wht = whiten(wht_r, rev8(crc_sel));

  always_comb begin
    crc_nxt       = crc_r;
    wht_nxt       = wht_r;
    start_nxt     = start_r;
    crc_left_nxt  = crc_left_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    is_crc_nxt    = is_crc_r;
    eop_nxt       = eop_r;
    if (in_fire) begin
      crc_nxt       = crc_feed(crc_base, in_data_byte);
      wht_nxt       = pay_wht.lfsr;
      start_nxt     = in_last_byte;
      crc_left_nxt  = in_last_byte ? 2'd3 : 2'd0;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rev8(pay_wht.data);
      is_crc_nxt    = 1'b0;
      eop_nxt       = 1'b0;
    end else if (crc_left_r != 2'd0 && out_free) begin
      wht_nxt       = crc_wht.lfsr;
      crc_left_nxt  = crc_left_r - 2'd1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rev8(crc_wht.data);
      is_crc_nxt    = 1'b1;
      eop_nxt       = (crc_left_r == 2'd1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= CRC_SEED_RST;
      chan_r      <= CHAN_RST;
      start_r     <= 1'b1;
      crc_left_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CRC_SEED: seed_r <= cfg_data;
          CFG_CHANNEL:  chan_r <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end
      start_r     <= start_nxt;
      crc_left_r  <= crc_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    wht_r      <= wht_nxt;
    out_byte_r <= out_byte_nxt;
    is_crc_r   <= is_crc_nxt;
    eop_r      <= eop_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_crc        = is_crc_r;
  assign out_end_of_packet = eop_r;

  a_last_queues_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> out_valid && !out_is_crc && crc_left_r == 2'd3)
    else $error("last word did not queue three crc words");

  a_no_input_during_crc: assert property (@(posedge clk) disable iff (!rst_n)
    crc_left_r != 2'd0 |-> !in_ready)
    else $error("input taken while crc words pending");

  a_eop_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_packet |-> out_is_crc)
    else $error("end of packet on a non-crc word");

  a_crc_closes_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_crc |-> start_r)
    else $error("crc word shown without packet restart pending");

endmodule

// File: sim/testbench.sv
// testbench for the ble advertising packet crc24 and whitening encoder
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int WORD_TARGET = 250;
  localparam logic [23:0] SEED_AFTER_RST = 24'h555555;
  localparam logic [5:0]  CHAN_AFTER_RST = 6'd37;
  localparam logic [23:0] CRC24_POLY     = 24'h00065B;
  localparam logic [7:0]  WHT_TAPS       = 8'h11;
  localparam logic [7:0]  WHT_FORCE_BIT  = 8'h02;

  typedef struct packed {
    logic [7:0] data;
    logic       crc_f;
    logic       eop_f;
  } air_word_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                            kind;
    logic [bleadv_pkg::CFG_IDX_W-1:0]     idx;
    logic [23:0]                          val;
    logic                                 last;
    logic                                 hand;
    logic [7:0]                           hand_byte;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [7:0]                         in_data_byte = 8'h00;
  logic                               in_last_byte = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [7:0]                         out_byte;
  logic                               out_is_crc;
  logic                               out_end_of_packet;
  logic                               cfg_we = 1'b0;
  logic [bleadv_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [bleadv_pkg::CFG_W-1:0]       cfg_data = '0;

  ble_adv_packet_crc_whitener u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_is_crc        (out_is_crc),
    .out_end_of_packet (out_end_of_packet),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // encoder model state
  logic [23:0] seed_cfg = SEED_AFTER_RST;
  logic [5:0]  chan_cfg = CHAN_AFTER_RST;
  logic [23:0] crc_acc;
  logic [7:0]  wht_acc;
  bit          pkt_open = 1'b0;
  air_word_t   air_q[$];

  int  err_cnt = 0;
  int  words_sent = 0;
  int  cycle_cnt = 0;
  bit  rx_quiet = 1'b0;
  bit  tx_quiet = 1'b0;
  int  rx_hold_req = 0;

  stim_row_t dir_rows[17];

  function automatic logic [7:0] flip8(input logic [7:0] a);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = a[k];
    end
    return r;
  endfunction

  function automatic void crc_absorb(input logic [7:0] d);
    logic top;
    for (int k = 0; k < 8; k++) begin
      top     = crc_acc[23];
      crc_acc = {crc_acc[22:0], 1'b0};
      if (top != d[k]) begin
        crc_acc = crc_acc ^ CRC24_POLY;
      end
    end
  endfunction

  // lfsr keeps running across payload and crc words
  function automatic logic [7:0] scramble(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    for (int k = 0; k < 8; k++) begin
      if (wht_acc[7]) begin
        wht_acc = wht_acc ^ WHT_TAPS;
        r[k]    = ~r[k];
      end
      wht_acc = {wht_acc[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void encode_payload_byte(input logic [7:0] d, input logic last);
    logic [7:0] c;
    if (!pkt_open) begin
      crc_acc  = seed_cfg;
      wht_acc  = flip8({2'b00, chan_cfg}) | WHT_FORCE_BIT;
      pkt_open = 1'b1;
    end
    crc_absorb(d);
    air_q.push_back('{flip8(scramble(d)), 1'b0, 1'b0});
    if (last) begin
      for (int k = 0; k < 3; k++) begin
        c = crc_acc[23-8*k -: 8];
        air_q.push_back('{flip8(scramble(flip8(c))), 1'b1, k == 2});
      end
      pkt_open = 1'b0;
    end
  endfunction

  function automatic int pause_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  // called at a rising edge; returns at the edge where the word was taken, or after a random pause behind it
  task automatic send_word(input logic [7:0] d, input logic last);
    int gap;
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    encode_payload_byte(d, last);
    words_sent++;
    gap = 0;
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      gap = pause_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet(input int len, input bit close);
    for (int i = 0; i < len; i++) begin
      send_word(8'($urandom_range(0, 255)), close && (i == len - 1));
    end
  endtask

  // wait until every expected word is out
  task automatic drain();
    in_valid <= 1'b0;
    while (air_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bleadv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bleadv_pkg::CFG_CRC_SEED) begin
      seed_cfg = val;
    end else begin
      chan_cfg = val[5:0];
    end
    @(posedge clk);
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("ble_adv_packet_crc_whitener verification failed");
    $finish;
  end

  // result side ready pattern
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold_left = pause_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // outputs are stable at the falling edge; a word seen here is taken at the next rise
  always @(negedge clk) begin
    air_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (air_q.size() == 0) begin
        $display("%0t: unexpected word %02h crc %0b eop %0b", $time,
                 out_byte, out_is_crc, out_end_of_packet);
        err_cnt++;
      end else begin
        exp_w = air_q.pop_front();
        if (out_byte !== exp_w.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, exp_w.data, out_byte);
          err_cnt++;
        end
        if (out_is_crc !== exp_w.crc_f) begin
          $display("%0t: out_is_crc expected %0b actual %0b", $time, exp_w.crc_f,
                   out_is_crc);
          err_cnt++;
        end
        if (out_end_of_packet !== exp_w.eop_f) begin
          $display("%0t: out_end_of_packet expected %0b actual %0b", $time, exp_w.eop_f,
                   out_end_of_packet);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int          n0;
    int          phase;
    int          npkt;
    int          len;
    logic [5:0]  chan;
    logic [23:0] seed;
    bit          close;

    // first word after reset: channel 37 seed, zero data gives b1 on air
    dir_rows = '{
      '{ROW_WORD, 1'b0, 24'h000000, 1'b0, 1'b1, 8'hB1},
      '{ROW_WORD, 1'b0, 24'h0000FF, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h000001, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h000080, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h000000, 1'b1, 1'b0, 8'h00},
      '{ROW_CFG,  bleadv_pkg::CFG_CHANNEL,  24'hFFFFC0, 1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  bleadv_pkg::CFG_CRC_SEED, 24'h000000, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h0000FF, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h000055, 1'b0, 1'b0, 8'h00},
      // written mid packet, so only the next packet sees these
      '{ROW_CFG,  bleadv_pkg::CFG_CHANNEL,  24'h000027, 1'b0, 1'b0, 8'h00},
      '{ROW_CFG,  bleadv_pkg::CFG_CRC_SEED, 24'hFFFFFF, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h0000AA, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h000000, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h0000FF, 1'b1, 1'b0, 8'h00},
      // channel above the valid range still seeds the lfsr
      '{ROW_CFG,  bleadv_pkg::CFG_CHANNEL,  24'h00003F, 1'b0, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h00005A, 1'b1, 1'b0, 8'h00},
      '{ROW_WORD, 1'b0, 24'h0000A5, 1'b1, 1'b0, 8'h00}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        n0 = air_q.size();
        send_word(dir_rows[i].val[7:0], dir_rows[i].last);
        if (dir_rows[i].hand) begin
          air_q[n0] = '{dir_rows[i].hand_byte, 1'b0, 1'b0};
        end
      end
    end

    phase = 0;
    while (words_sent < WORD_TARGET) begin
      drain();
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       seed = 24'h000000;
          1:       seed = 24'hFFFFFF;
          default: seed = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        write_reg(bleadv_pkg::CFG_CRC_SEED, seed);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       chan = 6'd0;
          1:       chan = 6'd39;
          2:       chan = 6'($urandom_range(40, 63));
          default: chan = 6'($urandom_range(0, 39));
        endcase
        // junk above the channel field is dropped
        write_reg(bleadv_pkg::CFG_CHANNEL, {18'($urandom_range(0, 18'h3FFFF)), chan});
      end

      if (phase == 2) begin
        // hold the result side off while words keep coming, so input backs up
        tx_quiet    = 1'b1;
        rx_quiet    = 1'b1;
        rx_hold_req = 80;
        send_packet(12, 1'b1);
      end else begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        npkt = $urandom_range(1, 4);
        for (int p = 0; p < npkt; p++) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
          // now and then leave a packet open across a register write
          close = !(p == npkt - 1 && $urandom_range(0, 5) == 0);
          send_packet(len, close);
        end
      end
      phase++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("ble_adv_packet_crc_whitener verification clean");
    end else begin
      $display("ble_adv_packet_crc_whitener verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bleadv_pkg.sv
hw/rtl/ble_adv_packet_crc_whitener.sv
sim/testbench.sv
